// ===== rtl/core/tss_pkg.sv =====
// Shared constants and helpers for the time-slice task scheduler.
`default_nettype none
package tss_pkg;
  localparam int unsigned DEF_TASK_SLOTS = 16;
  localparam int unsigned DEF_RUNNING_LIMIT = 8;
  localparam int unsigned DEF_READY_LIMIT = 8;
  localparam int unsigned DEF_PENDING_DEPTH = 8;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_KILL = 3'd2;
  localparam logic [2:0] OP_WAIT = 3'd3;
  localparam logic [2:0] OP_NOTIFY = 3'd4;

  localparam logic [1:0] KIND_TASK = 2'd0;
  localparam logic [1:0] KIND_LIMIT = 2'd3;

  localparam logic [31:0] FIRST_PID = 32'h10;
  localparam logic [8:0] RESET_BASE = 9'd260;
  localparam logic [8:0] FIRST_SLICE = 9'd60;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  function automatic logic [8:0] slice_for(input logic [8:0] base, input logic [7:0] pri);
    logic [8:0] p;
    p = {1'b0, pri};
    return (base <= p) ? 9'd1 : base - p;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/time_slice_task_scheduler_core.sv =====
// Top level of the time-slice task scheduler: command sequencer and task tables.
// One command is taken at a time and one result item is returned for it. The steps are:
// - a create, an unknown opcode, or a wait or notify of kind 3 goes from decode to finish;
// - a notify walks the wait list, one entry per waiting task, then finishes;
// - a tick, or a wait on a mutex or key, runs the scheduling steps, then finishes;
// - a wait on a pid first searches the slots, and finishes when no live task matches;
// - a kill walks the wait list, frees the slot and runs the scheduling steps, or goes
//   from decode to finish while the idle task runs.
// The scheduling steps (tick or wait, pending, run, fix, rotate, increment) promote
// pending creates and move ready tasks into the rotation. The sequencer walks the lists
// one entry per cycle. The input is not ready while a command is in progress or a result
// item waits, so the next item is taken at the earliest in the cycle after the result is
// accepted.
`default_nettype none
module time_slice_task_scheduler_core import tss_pkg::*; #(
  parameter int unsigned TASK_SLOTS = DEF_TASK_SLOTS,
  parameter int unsigned RUNNING_LIMIT = DEF_RUNNING_LIMIT,
  parameter int unsigned READY_LIMIT = DEF_READY_LIMIT,
  parameter int unsigned PENDING_DEPTH = DEF_PENDING_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,     // time_slice_base
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,      // priority_req, object_id
  input  wire logic [4:0]  s_tuser,      // opcode, wait_kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata       // current_slot, current_pid, ready_count,
                                         // running_count, pending_count, create_dropped,
                                         // woken_count, target_missing, zero fill
);
  localparam int unsigned SW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned IXW = $clog2(TASK_SLOTS);
  localparam int unsigned TCW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned RCW = $clog2(RUNNING_LIMIT + 2);
  localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
  localparam logic [SW-1:0] IDLE_SLOT = SW'(TASK_SLOTS);
  localparam logic [IXW-1:0] LAST_IX = IXW'(TASK_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_TICK, ST_PEND, ST_RUN, ST_FIX, ST_ROT, ST_INC,
    ST_WAKE, ST_KILL, ST_SEARCH, ST_WAIT, ST_FIN
  } state_t;

  state_t state;
  logic [8:0] time_slice_base;
  logic [2:0] op_r;
  logic [7:0] pri_r;
  logic [1:0] kind_r;
  logic [31:0] obj_r;
  logic [33:0] tag_r;
  logic [SW-1:0] kill_slot;
  logic ret_kill;
  logic [TCW-1:0] wake_left;
  logic [TCW-1:0] woken;
  logic dropped;
  logic missing;
  logic [IXW-1:0] idx;
  logic [31:0] next_pid;
  logic [31:0] task_pid [TASK_SLOTS];
  logic [8:0] slice_total [TASK_SLOTS];
  logic [8:0] slice_count [TASK_SLOTS + 1];
  logic [33:0] wait_tag [TASK_SLOTS];

  logic fr_push, fr_pop, rd_push, rd_pop, rn_push, rn_pop, wt_push, wt_pop;
  logic pd_push, pd_pop;
  logic [SW-1:0] rd_data, rn_data, wt_data, fr_front, rd_front, rn_front, wt_front;
  logic [7:0] pd_front;
  logic [TCW-1:0] fr_cnt, rd_cnt, wt_cnt;
  logic [RCW-1:0] rn_cnt;
  logic [PCW-1:0] pd_cnt;
  logic front_task;
  logic rdy_room;
  logic pend_room;
  logic run_room;
  logic wake_hit;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign front_task = (rn_cnt != '0) && (rn_front < IDLE_SLOT);
  assign rdy_room = 32'(rd_cnt) < READY_LIMIT;
  assign pend_room = 32'(pd_cnt) < PENDING_DEPTH;
  assign run_room = 32'(rn_cnt) < RUNNING_LIMIT;
  assign wake_hit = wait_tag[wt_front[IXW-1:0]] == tag_r;

  tss_queue #(.DEPTH(TASK_SLOTS), .W(SW), .INIT_COUNT(TASK_SLOTS - 1), .INIT_FIRST(1))
    u_free (.clk, .rst, .push(fr_push), .push_data(kill_slot), .pop(fr_pop),
            .front(fr_front), .count(fr_cnt));
  tss_queue #(.DEPTH(TASK_SLOTS), .W(SW), .INIT_COUNT(0), .INIT_FIRST(0))
    u_ready (.clk, .rst, .push(rd_push), .push_data(rd_data), .pop(rd_pop),
             .front(rd_front), .count(rd_cnt));
  tss_queue #(.DEPTH(RUNNING_LIMIT + 1), .W(SW), .INIT_COUNT(1), .INIT_FIRST(0))
    u_run (.clk, .rst, .push(rn_push), .push_data(rn_data), .pop(rn_pop),
           .front(rn_front), .count(rn_cnt));
  tss_queue #(.DEPTH(TASK_SLOTS), .W(SW), .INIT_COUNT(0), .INIT_FIRST(0))
    u_wait (.clk, .rst, .push(wt_push), .push_data(wt_data), .pop(wt_pop),
            .front(wt_front), .count(wt_cnt));
  tss_queue #(.DEPTH(PENDING_DEPTH), .W(8), .INIT_COUNT(0), .INIT_FIRST(0))
    u_pend (.clk, .rst, .push(pd_push), .push_data(pri_r), .pop(pd_pop),
            .front(pd_front), .count(pd_cnt));

  always_comb begin
    fr_push = 1'b0; fr_pop = 1'b0; rd_push = 1'b0; rd_pop = 1'b0;
    rn_push = 1'b0; rn_pop = 1'b0; wt_push = 1'b0; wt_pop = 1'b0;
    pd_push = 1'b0; pd_pop = 1'b0;
    rd_data = rn_front; rn_data = rn_front; wt_data = rn_front;
    unique case (state)
      ST_DEC: begin
        if (op_r == OP_CREATE) begin
          pd_push = pend_room;
        end else if (op_r == OP_KILL) begin
          rn_pop = front_task;
        end
      end
      ST_TICK: begin
        if (front_task && (slice_count[rn_front] == slice_total[rn_front[IXW-1:0]])) begin
          rn_pop = 1'b1;
          rd_push = 1'b1;
        end
      end
      ST_PEND: begin
        if ((pd_cnt != '0) && rdy_room && (fr_cnt != '0)) begin
          fr_pop = 1'b1;
          pd_pop = 1'b1;
          rd_push = 1'b1;
          rd_data = fr_front;
        end
      end
      ST_RUN: begin
        if ((rd_cnt != '0) && run_room) begin
          rd_pop = 1'b1;
          rn_push = 1'b1;
          rn_data = rd_front;
        end
      end
      ST_FIX: begin
        if (rn_cnt == '0) begin
          rn_push = 1'b1;
          rn_data = IDLE_SLOT;
        end else if ((rn_cnt > RCW'(1)) && (rn_front == IDLE_SLOT)) begin
          rn_pop = 1'b1;
        end
      end
      ST_ROT: begin
        rn_pop = 1'b1;
        rn_push = 1'b1;
      end
      ST_WAKE: begin
        if (wake_left != '0) begin
          wt_pop = 1'b1;
          rd_data = wt_front;
          wt_data = wt_front;
          rd_push = wake_hit;
          wt_push = !wake_hit;
        end
      end
      ST_KILL: fr_push = 1'b1;
      ST_WAIT: begin
        rn_pop = front_task;
        wt_push = front_task;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && front_task) begin
      wait_tag[rn_front[IXW-1:0]] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      time_slice_base <= RESET_BASE;
      m_tvalid <= 1'b0;
      next_pid <= FIRST_PID + 32'd1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        task_pid[i] <= (i == 0) ? FIRST_PID : '0;
        slice_total[i] <= (i == 0) ? FIRST_SLICE : '0;
      end
      for (int i = 0; i <= TASK_SLOTS; i++) begin
        slice_count[i] <= (i == 0) ? 9'd1 : '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        time_slice_base <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            op_r <= s_tuser[2:0];
            kind_r <= s_tuser[4:3];
            pri_r <= s_tdata[7:0];
            obj_r <= s_tdata[39:8];
            tag_r <= {s_tuser[4:3], s_tdata[39:8]};
            dropped <= 1'b0;
            missing <= 1'b0;
            woken <= '0;
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          wake_left <= wt_cnt;
          idx <= '0;
          case (op_r)
            OP_TICK: state <= ST_TICK;
            OP_CREATE: begin
              dropped <= !pend_room;
              state <= ST_FIN;
            end
            OP_KILL: begin
              if (!front_task) begin
                missing <= 1'b1;
                state <= ST_FIN;
              end else begin
                tag_r <= {2'b00, task_pid[rn_front[IXW-1:0]]};
                kill_slot <= rn_front;
                ret_kill <= 1'b1;
                state <= ST_WAKE;
              end
            end
            OP_WAIT: begin
              if (kind_r != KIND_LIMIT) begin
                state <= (kind_r == KIND_TASK) ? ST_SEARCH : ST_WAIT;
              end else begin
                state <= ST_FIN;
              end
            end
            OP_NOTIFY: begin
              if (kind_r != KIND_LIMIT) begin
                ret_kill <= 1'b0;
                state <= ST_WAKE;
              end else begin
                state <= ST_FIN;
              end
            end
            default: state <= ST_FIN;
          endcase
        end
        ST_TICK: state <= ST_PEND;
        ST_PEND: begin
          if (fr_pop) begin
            task_pid[fr_front[IXW-1:0]] <= next_pid;
            next_pid <= (next_pid == '1) ? 32'd1 : next_pid + 32'd1;
            slice_total[fr_front[IXW-1:0]] <= slice_for(time_slice_base, pd_front);
            slice_count[fr_front] <= '0;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (rd_pop) begin
            slice_count[rd_front] <= '0;
          end else begin
            state <= ST_FIX;
          end
        end
        ST_FIX: state <= ST_ROT;
        ST_ROT: state <= ST_INC;
        ST_INC: begin
          if (slice_count[rn_front] != COUNT_MAX) begin
            slice_count[rn_front] <= slice_count[rn_front] + 9'd1;
          end
          state <= ST_FIN;
        end
        ST_WAKE: begin
          if (wake_left == '0) begin
            state <= ret_kill ? ST_KILL : ST_FIN;
          end else begin
            wake_left <= wake_left - 1'b1;
            if (wake_hit) begin
              woken <= woken + 1'b1;
            end
          end
        end
        ST_KILL: begin
          task_pid[kill_slot[IXW-1:0]] <= '0;
          state <= ST_TICK;
        end
        ST_SEARCH: begin
          if ((task_pid[idx] != '0) && (task_pid[idx] == obj_r)) begin
            state <= ST_WAIT;
          end else if (idx == LAST_IX) begin
            missing <= 1'b1;
            state <= ST_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_WAIT: state <= ST_PEND;
        ST_FIN: begin
          m_tvalid <= 1'b1;
          m_tdata <= {7'd0, missing, 5'(woken), dropped, 4'(pd_cnt), 4'(rn_cnt),
                      5'(rd_cnt), front_task ? task_pid[rn_front[IXW-1:0]] : 32'd0,
                      (rn_cnt != '0) ? 5'(rn_front) : 5'(IDLE_SLOT)};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rotation_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (rn_cnt != '0))
    else $error("running rotation empty between commands");
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FIN))
    else $error("result raised outside the finishing step");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new item taken while a command is in progress");
endmodule
`default_nettype wire

// ===== rtl/core/tss_queue.sv =====
// Circular first-in first-out list of slot numbers or priorities.
`default_nettype none
module tss_queue import tss_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned W = 5,
  parameter int unsigned INIT_COUNT = 0,
  parameter int unsigned INIT_FIRST = 0,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [W-1:0]  push_data,
  input  wire logic          pop,
  output logic      [W-1:0]  front,
  output logic      [CW-1:0] count
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW:0] DEPTH_X = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail;
  logic [IW:0] tsum;
  logic do_pop;
  logic do_push;

  assign do_pop = pop && (count != '0);
  assign do_push = push && ((count < DEPTH_C) || do_pop);
  assign tsum = {1'b0, head} + (IW + 1)'(count);
  assign tail = (tsum >= DEPTH_X) ? IW'(tsum - DEPTH_X) : tsum[IW-1:0];
  assign head_next = ({1'b0, head} == DEPTH_X - 1'b1) ? '0 : head + 1'b1;
  assign front = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= CW'(INIT_COUNT);
      for (int i = 0; i < DEPTH; i++) begin
        mem[i] <= (i < INIT_COUNT) ? W'(INIT_FIRST + i) : '0;
      end
    end else begin
      if (do_push) begin
        mem[tail] <= push_data;
      end
      if (do_pop) begin
        head <= head_next;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_time_slice_task_scheduler_core.sv =====
// Self-checking testbench for the time-slice task scheduler core.
`default_nettype none
module tb_time_slice_task_scheduler_core import tss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = DEF_TASK_SLOTS;
  localparam logic [4:0] IDLE = 5'(SLOTS);
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [1:0] KIND_MUTEX = 2'd1;
  localparam logic [1:0] KIND_KEY = 2'd2;

  // Packed from the most significant field down, so the first field lands in the highest bits.
  typedef struct packed {
    logic        target_missing;
    logic [4:0]  woken_count;
    logic        create_dropped;
    logic [3:0]  pending_count;
    logic [3:0]  running_count;
    logic [4:0]  ready_count;
    logic [31:0] current_pid;
    logic [4:0]  current_slot;
  } sched_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic [4:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;

  time_slice_task_scheduler_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Scheduler state mirrored by the testbench.
  logic [8:0]  slice_base;
  logic [31:0] pid_of [SLOTS];
  logic [8:0]  slice_len [SLOTS];
  logic [8:0]  slice_used [SLOTS+1];
  logic [33:0] blocked_on [SLOTS];
  logic [4:0]  waiters[$], free_slots[$], ready_slots[$], rotation[$];
  logic [7:0]  queued_pri[$];
  logic [31:0] pid_next;

  sched_status_t status_queue[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic void push_cap(ref logic [4:0] q[$], input int cap, input logic [4:0] v);
    if (q.size() < cap) q.push_back(v);
  endfunction

  function automatic logic [4:0] pop_front(ref logic [4:0] q[$]);
    if (q.size() == 0) return 5'd0;
    return q.pop_front();
  endfunction

  function automatic logic [4:0] front_task();
    return rotation.size() > 0 ? rotation[0] : IDLE;
  endfunction

  function automatic void model_reset();
    slice_base = RESET_BASE;
    waiters.delete(); free_slots.delete(); ready_slots.delete();
    rotation.delete(); queued_pri.delete();
    for (int i = 0; i < SLOTS; i++) begin
      pid_of[i] = '0;
      slice_len[i] = '0;
      blocked_on[i] = '0;
    end
    for (int i = 0; i <= SLOTS; i++) slice_used[i] = '0;
    for (int i = 1; i < SLOTS; i++) free_slots.push_back(5'(i));
    pid_of[0] = FIRST_PID;
    slice_len[0] = FIRST_SLICE;
    slice_used[0] = 9'd1;
    rotation.push_back(5'd0);
    pid_next = FIRST_PID + 1;
  endfunction

  function automatic int wake_matching(input logic [33:0] tag);
    logic [4:0] kept[$];
    int n;
    n = 0;
    foreach (waiters[i]) begin
      if (blocked_on[waiters[i]] == tag) begin
        push_cap(ready_slots, SLOTS, waiters[i]);
        n++;
      end else begin
        kept.push_back(waiters[i]);
      end
    end
    waiters = kept;
    return n;
  endfunction

  function automatic void reschedule();
    logic [4:0] s;
    logic [8:0] p;
    while (queued_pri.size() > 0 && ready_slots.size() < DEF_READY_LIMIT
           && free_slots.size() > 0) begin
      s = pop_front(free_slots);
      pid_of[s] = pid_next;
      pid_next = pid_next + 1;
      if (pid_next == 0) pid_next = 1;
      p = {1'b0, queued_pri.pop_front()};
      slice_len[s] = (slice_base <= p) ? 9'd1 : slice_base - p;
      slice_used[s] = '0;
      push_cap(ready_slots, SLOTS, s);
    end
    while (ready_slots.size() > 0 && rotation.size() < DEF_RUNNING_LIMIT) begin
      s = pop_front(ready_slots);
      slice_used[s] = '0;
      push_cap(rotation, DEF_RUNNING_LIMIT + 1, s);
    end
    if (rotation.size() == 0) rotation.push_back(IDLE);
    else if (rotation.size() > 1 && rotation[0] == IDLE) void'(rotation.pop_front());
    s = pop_front(rotation);
    push_cap(rotation, DEF_RUNNING_LIMIT + 1, s);
    s = front_task();
    if (slice_used[s] < COUNT_MAX) slice_used[s]++;
  endfunction

  function automatic void clock_tick();
    logic [4:0] s;
    s = front_task();
    if (s < IDLE && slice_used[s] == slice_len[s]) begin
      void'(rotation.pop_front());
      push_cap(ready_slots, SLOTS, s);
    end
    reschedule();
  endfunction

  function automatic sched_status_t run_command(input logic [2:0] op, input logic [7:0] pri,
                                                input logic [1:0] kind,
                                                input logic [31:0] obj);
    sched_status_t r;
    logic [4:0] s;
    bit found;
    r = '0;
    case (op)
      OP_TICK: clock_tick();
      OP_CREATE: begin
        if (queued_pri.size() < DEF_PENDING_DEPTH) queued_pri.push_back(pri);
        else r.create_dropped = 1'b1;
      end
      OP_KILL: begin
        s = front_task();
        if (s == IDLE) begin
          r.target_missing = 1'b1;
        end else begin
          void'(rotation.pop_front());
          r.woken_count = 5'(wake_matching({KIND_TASK, pid_of[s]}));
          pid_of[s] = '0;
          push_cap(free_slots, SLOTS, s);
          clock_tick();
        end
      end
      OP_WAIT: if (kind != KIND_LIMIT) begin
        found = (kind != KIND_TASK);
        for (int i = 0; i < SLOTS; i++)
          if (pid_of[i] != 0 && pid_of[i] == obj) found = 1'b1;
        if (!found) begin
          r.target_missing = 1'b1;
        end else begin
          s = front_task();
          if (s < IDLE) begin
            void'(rotation.pop_front());
            blocked_on[s] = {kind, obj};
            push_cap(waiters, SLOTS, s);
          end
          reschedule();
        end
      end
      OP_NOTIFY: if (kind != KIND_LIMIT) r.woken_count = 5'(wake_matching({kind, obj}));
      default: ;
    endcase
    s = front_task();
    r.current_slot = s;
    r.current_pid = (s < IDLE) ? pid_of[s] : '0;
    r.ready_count = 5'(ready_slots.size());
    r.running_count = 4'(rotation.size());
    r.pending_count = 4'(queued_pri.size());
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sched_status_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[56:0];
      if (status_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = status_queue.pop_front();
        if (got.current_slot !== want.current_slot) begin
          $display("%0t: current_slot expected %0d got %0d", $time,
                   want.current_slot, got.current_slot);
          errors++;
        end
        if (got.current_pid !== want.current_pid) begin
          $display("%0t: current_pid expected %0d got %0d", $time,
                   want.current_pid, got.current_pid);
          errors++;
        end
        if (got.ready_count !== want.ready_count) begin
          $display("%0t: ready_count expected %0d got %0d", $time,
                   want.ready_count, got.ready_count);
          errors++;
        end
        if (got.running_count !== want.running_count) begin
          $display("%0t: running_count expected %0d got %0d", $time,
                   want.running_count, got.running_count);
          errors++;
        end
        if (got.pending_count !== want.pending_count) begin
          $display("%0t: pending_count expected %0d got %0d", $time,
                   want.pending_count, got.pending_count);
          errors++;
        end
        if (got.create_dropped !== want.create_dropped) begin
          $display("%0t: create_dropped expected %0d got %0d", $time,
                   want.create_dropped, got.create_dropped);
          errors++;
        end
        if (got.woken_count !== want.woken_count) begin
          $display("%0t: woken_count expected %0d got %0d", $time,
                   want.woken_count, got.woken_count);
          errors++;
        end
        if (got.target_missing !== want.target_missing) begin
          $display("%0t: target_missing expected %0d got %0d", $time,
                   want.target_missing, got.target_missing);
          errors++;
        end
      end
    end
  end

  task automatic send_command(input logic [2:0] op, input logic [7:0] pri,
                              input logic [1:0] kind, input logic [31:0] obj);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {obj, pri};
    s_tuser <= {kind, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    status_queue.push_back(run_command(op, pri, kind, obj));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (status_queue.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_base(input logic [8:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slice_base = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_command(3'd7, 8'hFF, 2'd3, 32'hFFFFFFFF);
    send_command(OP_KILL, 8'd0, KIND_TASK, 32'd0);
    send_command(OP_KILL, 8'd0, KIND_TASK, 32'd0);
    send_command(OP_WAIT, 8'd0, KIND_TASK, 32'd0);
    send_command(OP_WAIT, 8'd0, KIND_MUTEX, 32'd3);
    for (int i = 0; i < 9; i++) send_command(OP_CREATE, (i == 1) ? 8'd255 : 8'(i * 31),
                                             KIND_TASK, 32'd0);
    send_command(OP_TICK, 8'd0, KIND_TASK, 32'd0);
    send_command(OP_TICK, 8'd0, KIND_TASK, 32'd0);
    send_command(OP_WAIT, 8'd0, KIND_TASK, 32'd17);
    send_command(OP_WAIT, 8'd0, KIND_MUTEX, 32'hFFFFFFFF);
    send_command(OP_WAIT, 8'd0, KIND_KEY, 32'd5);
    send_command(OP_NOTIFY, 8'd0, KIND_MUTEX, 32'hFFFFFFFF);
    send_command(OP_NOTIFY, 8'd0, KIND_KEY, 32'd5);
    send_command(OP_NOTIFY, 8'd0, KIND_LIMIT, 32'd5);
    send_command(OP_WAIT, 8'd0, KIND_LIMIT, 32'd5);
    send_command(3'd5, 8'd0, KIND_TASK, 32'd0);
    send_command(3'd6, 8'd0, KIND_TASK, 32'd0);
    send_command(OP_KILL, 8'd0, KIND_TASK, 32'd0);
  endtask

  task automatic send_random();
    int r;
    logic [1:0] kind;
    logic [31:0] obj;
    r = $urandom_range(99);
    kind = 2'($urandom_range(2));
    if ($urandom_range(19) == 0) kind = KIND_LIMIT;
    if (kind == KIND_TASK) obj = ($urandom_range(4) != 0) ? pid_of[$urandom_range(SLOTS - 1)]
                                                          : $urandom();
    else obj = ($urandom_range(9) != 0) ? 32'($urandom_range(3)) : $urandom();
    if (r < 40) send_command(OP_TICK, 8'($urandom()), kind, obj);
    else if (r < 60) send_command(OP_CREATE, 8'($urandom()), kind, obj);
    else if (r < 68) send_command(OP_KILL, 8'($urandom()), kind, obj);
    else if (r < 83) send_command(OP_WAIT, 8'($urandom()), kind, obj);
    else if (r < 97) send_command(OP_NOTIFY, 8'($urandom()), kind, obj);
    else send_command(3'($urandom_range(5, 7)), 8'($urandom()), kind, obj);
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_random();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_random();
  endtask

  initial begin
    model_reset();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(150, 0, 0);
    write_base(9'd256);
    test_random(150, 78, 0);
    write_base(9'd511);
    test_random(150, 0, 78);
    test_backpressure();
    write_base(9'($urandom_range(256, 511)));
    test_random(150, 28, 28);
    write_base(RESET_BASE);
    test_random(60, 0, 0);
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/tss_pkg.sv
rtl/core/tss_queue.sv
rtl/core/time_slice_task_scheduler_core.sv
bench/tb_time_slice_task_scheduler_core.sv
